// ===== src/cci_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// CIGAR clip/insertion locator package
// Shared widths, operation and fragment codes, and the read summary record
// that travels from the front end to the fragment emitter.
// ---------------------------------------------------------------------------
package cci_pkg;

   localparam int LEN_WIDTH   = 28;
   localparam int TOP_INSERTS = 2;
   localparam int RESULT_CAP  = 4;
   localparam int FRAG_SLOTS  = 2 + TOP_INSERTS;
   localparam int INS_CNT_W   = $clog2(TOP_INSERTS + 1);
   localparam int SLOT_W      = $clog2(FRAG_SLOTS);
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CODE_W      = 4;
   localparam int KIND_W      = 2;

   localparam logic [CODE_W-1:0] CIGAR_M  = 4'd0;
   localparam logic [CODE_W-1:0] CIGAR_I  = 4'd1;
   localparam logic [CODE_W-1:0] CIGAR_S  = 4'd4;
   localparam logic [CODE_W-1:0] CIGAR_H  = 4'd5;
   localparam logic [CODE_W-1:0] CIGAR_EQ = 4'd7;
   localparam logic [CODE_W-1:0] CIGAR_X  = 4'd8;

   localparam logic [KIND_W-1:0] KIND_LEFT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RIGHT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CLIP   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INSERT = 1'b1;

   localparam int SLOT_LEFT  = 0;
   localparam int SLOT_RIGHT = 1;
   localparam int SLOT_INS0  = 2;

   typedef logic [LEN_WIDTH-1:0]  len_type;
   typedef logic [INS_CNT_W-1:0]  ins_cnt_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [FRAG_SLOTS-1:0] slot_mask_type;

   typedef struct packed {
      len_type min_clip_len;
      len_type min_insert_len;
   } cfg_type;

   typedef struct packed {
      len_type                       lead_len;
      len_type                       trail_len;
      len_type                       right_start;
      len_type [TOP_INSERTS-1:0]     ins_start;
      len_type [TOP_INSERTS-1:0]     ins_len;
      logic                          split_class;
      logic                          clip_class;
      logic                          insert_class;
      logic                          reverse;
      slot_mask_type                 mask;
   } summary_type;

   // keep only the first RESULT_CAP pending fragments
   function automatic slot_mask_type cap_mask(input slot_mask_type m);
      slot_mask_type r;
      int            cnt;
      r   = '0;
      cnt = 0;
      for (int i = 0; i < FRAG_SLOTS; i++) begin
         if (m[i] && cnt < RESULT_CAP) begin
            r[i] = 1'b1;
            cnt  = cnt + 1;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/cci_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// CIGAR locator front end
// Walks one read's operations, tracks query position, clips and the ranked
// insertions, and hands a read summary to the queue on the last operation.
// ---------------------------------------------------------------------------
module cci_front import cci_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              item_valid,
   input  wire logic [CODE_W-1:0] cigar_code,
   input  wire len_type           cigar_len,
   input  wire logic              last_op,
   input  wire len_type           read_length,
   input  wire logic              split_flag,
   input  wire logic              reverse_strand,
   output logic                   sum_valid,
   output summary_type            summary
);

   len_type                   qpos_ff, qpos_in;
   logic                      seen_ff, seen_in;
   len_type                   lead_ff, lead_in;
   logic                      tail_soft_ff, tail_soft_in;
   len_type                   tail_len_ff, tail_len_in;
   len_type [TOP_INSERTS-1:0] ins_start_ff, ins_start_in;
   len_type [TOP_INSERTS-1:0] ins_len_ff, ins_len_in;
   ins_cnt_type               cnt_ff, cnt_in;

   len_type                   lead_u, tail_len_u, qpos_u, trailing;
   logic                      tail_soft_u, seen_u;
   len_type [TOP_INSERTS-1:0] ins_start_u, ins_len_u;
   ins_cnt_type               cnt_u, pos;
   logic                      do_rank, lead_ok, trail_ok;
   logic [LEN_WIDTH:0]        qsum;
   slot_mask_type             raw_mask;

   always_comb begin
      seen_u      = seen_ff;
      lead_u      = lead_ff;
      tail_soft_u = tail_soft_ff;
      tail_len_u  = tail_len_ff;
      if (cigar_code != CIGAR_H) begin
         if (!seen_ff) begin
            seen_u = 1'b1;
            lead_u = (cigar_code == CIGAR_S) ? cigar_len : '0;
         end
         tail_soft_u = (cigar_code == CIGAR_S);
         tail_len_u  = cigar_len;
      end

      pos = '0;
      for (int i = 0; i < TOP_INSERTS; i++) begin
         if (ins_cnt_type'(i) < cnt_ff && ins_len_ff[i] >= cigar_len) begin
            pos = pos + 1'b1;
         end
      end
      do_rank = (cigar_code == CIGAR_I) && (cigar_len >= cfg.min_insert_len) &&
                (int'(pos) < TOP_INSERTS);
      ins_start_u = ins_start_ff;
      ins_len_u   = ins_len_ff;
      cnt_u       = cnt_ff;
      if (do_rank) begin
         if (int'(cnt_ff) < TOP_INSERTS) begin
            cnt_u = cnt_ff + 1'b1;
         end
         for (int k = 0; k < TOP_INSERTS; k++) begin
            if (ins_cnt_type'(k) == pos) begin
               ins_start_u[k] = qpos_ff;
               ins_len_u[k]   = cigar_len;
            end else if (ins_cnt_type'(k) > pos && k > 0) begin
               ins_start_u[k] = ins_start_ff[(k > 0) ? k - 1 : 0];
               ins_len_u[k]   = ins_len_ff[(k > 0) ? k - 1 : 0];
            end
         end
      end

      qsum   = {1'b0, qpos_ff} + {1'b0, cigar_len};
      qpos_u = qpos_ff;
      if (cigar_code == CIGAR_M || cigar_code == CIGAR_I || cigar_code == CIGAR_S ||
          cigar_code == CIGAR_EQ || cigar_code == CIGAR_X) begin
         qpos_u = qsum[LEN_WIDTH] ? '1 : qsum[LEN_WIDTH-1:0];
      end

      trailing = tail_soft_u ? tail_len_u : '0;
      lead_ok  = lead_u >= cfg.min_clip_len;
      trail_ok = trailing >= cfg.min_clip_len;

      raw_mask             = '0;
      raw_mask[SLOT_LEFT]  = lead_ok && (lead_u != '0);
      raw_mask[SLOT_RIGHT] = trail_ok && (trailing != '0);
      for (int i = 0; i < TOP_INSERTS; i++) begin
         raw_mask[SLOT_INS0+i] = ins_len_u[i] != '0;
      end

      summary.lead_len     = lead_u;
      summary.trail_len    = trailing;
      summary.right_start  = (read_length >= trailing) ? (read_length - trailing) : '0;
      summary.ins_start    = ins_start_u;
      summary.ins_len      = ins_len_u;
      summary.split_class  = split_flag;
      summary.clip_class   = lead_ok || trail_ok;
      summary.insert_class = cnt_u != '0;
      summary.reverse      = reverse_strand;
      summary.mask         = cap_mask(raw_mask);
      sum_valid            = item_valid && last_op;

      if (last_op) begin
         qpos_in      = '0;
         seen_in      = 1'b0;
         lead_in      = '0;
         tail_soft_in = 1'b0;
         tail_len_in  = '0;
         ins_start_in = '0;
         ins_len_in   = '0;
         cnt_in       = '0;
      end else begin
         qpos_in      = qpos_u;
         seen_in      = seen_u;
         lead_in      = lead_u;
         tail_soft_in = tail_soft_u;
         tail_len_in  = tail_len_u;
         ins_start_in = ins_start_u;
         ins_len_in   = ins_len_u;
         cnt_in       = cnt_u;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qpos_ff      <= '0;
         seen_ff      <= 1'b0;
         lead_ff      <= '0;
         tail_soft_ff <= 1'b0;
         tail_len_ff  <= '0;
         ins_start_ff <= '0;
         ins_len_ff   <= '0;
         cnt_ff       <= '0;
      end else if (item_valid) begin
         qpos_ff      <= qpos_in;
         seen_ff      <= seen_in;
         lead_ff      <= lead_in;
         tail_soft_ff <= tail_soft_in;
         tail_len_ff  <= tail_len_in;
         ins_start_ff <= ins_start_in;
         ins_len_ff   <= ins_len_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/cci_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// CIGAR locator summary queue
// Short FIFO of read summaries between the front end and the emitter.
// ---------------------------------------------------------------------------
module cci_queue import cci_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire summary_type push_data,
   input  wire logic        pop,
   output logic             full,
   output logic             empty,
   output summary_type      head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   summary_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     do_push, do_pop;

   always_comb begin
      full      = count_ff == CNT_W'(QUEUE_DEPTH);
      empty     = count_ff == '0;
      head      = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== src/cci_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// CIGAR locator fragment emitter
// Takes read summaries from the queue and sends their pending fragments one
// per transfer through a registered output stage.
// ---------------------------------------------------------------------------
module cci_back import cci_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_empty,
   input  wire summary_type q_head,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,
   output logic [5:0]       rsp_tuser,
   output logic             rsp_tlast
);

   summary_type         cur_ff, cur_in;
   slot_mask_type       mask_ff, mask_in;
   logic                valid_ff, valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   len_type             start_ff, start_in;
   len_type             length_ff, length_in;
   logic                last_ff, last_in;
   logic [3:0]          flags_ff, flags_in;

   logic                out_free, do_emit;
   slot_type            pick;
   slot_mask_type       mask_left;

   always_comb begin
      out_free = !valid_ff || rsp_tready;
      do_emit  = out_free && (mask_ff != '0);

      pick = '0;
      for (int i = FRAG_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pick = slot_type'(i);
         end
      end
      mask_left       = mask_ff;
      mask_left[pick] = 1'b0;

      kind_in   = kind_ff;
      start_in  = start_ff;
      length_in = length_ff;
      last_in   = last_ff;
      flags_in  = flags_ff;
      valid_in  = valid_ff && !rsp_tready;
      mask_in   = mask_ff;
      cur_in    = cur_ff;

      if (do_emit) begin
         valid_in = 1'b1;
         last_in  = mask_left == '0;
         flags_in = {cur_ff.reverse, cur_ff.insert_class, cur_ff.clip_class,
                     cur_ff.split_class};
         mask_in  = mask_left;
         if (pick == slot_type'(SLOT_LEFT)) begin
            kind_in   = KIND_LEFT;
            start_in  = '0;
            length_in = cur_ff.lead_len;
         end else if (pick == slot_type'(SLOT_RIGHT)) begin
            kind_in   = KIND_RIGHT;
            start_in  = cur_ff.right_start;
            length_in = cur_ff.trail_len;
         end else begin
            kind_in = KIND_INSERT;
            for (int i = 0; i < TOP_INSERTS; i++) begin
               if (pick == slot_type'(SLOT_INS0 + i)) begin
                  start_in  = cur_ff.ins_start[i];
                  length_in = cur_ff.ins_len[i];
               end
            end
         end
      end

      q_pop = !q_empty && ((mask_ff == '0) || (do_emit && mask_left == '0));
      if (q_pop) begin
         cur_in  = q_head;
         mask_in = q_head.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mask_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         mask_ff  <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      kind_ff   <= kind_in;
      start_ff  <= start_in;
      length_ff <= length_in;
      last_ff   <= last_in;
      flags_ff  <= flags_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {length_ff, start_ff};
   assign rsp_tuser  = {flags_ff, kind_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// ===== src/cigar_clip_insertion_locator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// CIGAR soft clip and insertion locator
// Scans a read's CIGAR operations and emits its left clip, right clip and
// longest insertions as fragments.
// ---------------------------------------------------------------------------
// One CIGAR operation is taken per cycle; the front end updates its position,
// clip and insertion ranking registers in that cycle, and req_tready drops
// only while the two-entry summary queue is full. Each read then gives the
// emitter one fragment per transfer (at most four); a read with no fragment
// still takes a turn, so sustained throughput is one operation per cycle
// while rsp_tready stays high and reads average no fewer operations than fragments.
// Configuration writes are taken every cycle and must be made while idle.
// ---------------------------------------------------------------------------
module cigar_clip_insertion_locator import cci_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire len_type              csr_data,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // cigar_code[3:0], cigar_len[31:4], read_length[59:32], zero fill
   input  wire logic [63:0]          req_tdata,
   // has_split_tag[0], is_supplementary[1], reverse_strand[2]
   input  wire logic [2:0]           req_tuser,
   input  wire logic                 req_tlast,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // frag_start[27:0], frag_length[55:28]
   output logic [55:0]               rsp_tdata,
   // frag_kind[1:0], split_class[2], clip_class[3], insert_class[4], frag_reverse[5]
   output logic [5:0]                rsp_tuser,
   output logic                      rsp_tlast
);

   cfg_type      cfg_ff;
   logic         q_full, q_empty, q_pop, sum_valid, item_valid;
   summary_type  summary, q_head;
   logic [3:0]   unused_pad;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign item_valid = req_tvalid && req_tready;
   assign unused_pad = req_tdata[63:60];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_CLIP:   cfg_ff.min_clip_len   <= csr_data;
            CSR_MIN_INSERT: cfg_ff.min_insert_len <= csr_data;
            default:        cfg_ff                <= cfg_ff;
         endcase
      end
   end

   cci_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .item_valid     (item_valid),
      .cigar_code     (req_tdata[3:0]),
      .cigar_len      (req_tdata[31:4]),
      .last_op        (req_tlast),
      .read_length    (req_tdata[59:32]),
      .split_flag     (req_tuser[0] | req_tuser[1] | (unused_pad != 4'd0 && 1'b0)),
      .reverse_strand (req_tuser[2]),
      .sum_valid      (sum_valid),
      .summary        (summary)
   );

   cci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (sum_valid),
      .push_data (summary),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   cci_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// CIGAR clip/insertion locator testbench
// Streams directed and random reads of CIGAR operations through the block
// under several threshold settings, predicts every clip and insertion
// fragment, and checks each fragment transfer in order against the
// prediction. Both stream sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb_top;
   import cci_pkg::*;

   localparam logic [CODE_W-1:0] OP_D        = 4'd2;
   localparam logic [CODE_W-1:0] OP_N        = 4'd3;
   localparam logic [CODE_W-1:0] OP_P        = 4'd6;
   localparam logic [CODE_W-1:0] OP_RSVD_LO  = 4'd12;
   localparam logic [CODE_W-1:0] OP_RSVD_HI  = 4'd15;
   localparam len_type           LEN_MAX     = '1;
   localparam int                DRAIN_WAIT  = 16;
   localparam int                REPORT_MAX  = 10;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      len_type           len;
      logic              last;
      len_type           rlen;
      logic [2:0]        flags;   // reverse, supplementary, split tag
   } cigar_op_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      len_type           start;
      len_type           length;
      logic              split_cls;
      logic              clip_cls;
      logic              ins_cls;
      logic              reverse;
      logic              last;
   } frag_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   len_type              csr_data   = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata  = '0;
   logic [2:0]           req_tuser  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [55:0]          rsp_tdata;
   logic [5:0]           rsp_tuser;
   logic                 rsp_tlast;

   cigar_op_type cigar_ops [$];
   frag_type     frags_due [$];
   cigar_op_type cur_op;
   frag_type     want;
   frag_type     got;
   int        ops_sent  = 0;
   int        ops_taken = 0;
   int        errors    = 0;
   int        req_gap   = 0;
   int        rsp_stall = 0;
   bit        req_steady = 1'b0;
   bit        rsp_steady = 1'b0;

   len_type   clip_thresh   = '0;
   len_type   insert_thresh = '0;
   len_type   qpos;
   bit        seen_body;
   len_type   lead_clip;
   bit        tail_soft;
   len_type   tail_len;
   len_type   ins_start [TOP_INSERTS];
   len_type   ins_len [TOP_INSERTS];
   int        ins_cnt;

   cigar_clip_insertion_locator uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic bit consumes_query(input logic [CODE_W-1:0] code);
      return code == CIGAR_M || code == CIGAR_I || code == CIGAR_S ||
             code == CIGAR_EQ || code == CIGAR_X;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic len_type rand_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 78) return len_type'($urandom_range(1, 40));
      if (r < 90) return len_type'($urandom_range(41, 300));
      if (r < 96) return len_type'($urandom);
      return LEN_MAX - len_type'($urandom_range(0, 1));
   endfunction

   function automatic logic [CODE_W-1:0] pick_mid_code();
      case ($urandom_range(0, 7))
         0: return CIGAR_M;
         1: return CIGAR_I;
         2: return CIGAR_I;
         3: return OP_D;
         4: return OP_N;
         5: return CIGAR_EQ;
         6: return CIGAR_X;
         default: return OP_P;
      endcase
   endfunction

   task automatic clear_scan();
      qpos      = '0;
      seen_body = 1'b0;
      lead_clip = '0;
      tail_soft = 1'b0;
      tail_len  = '0;
      ins_cnt   = 0;
      for (int i = 0; i < TOP_INSERTS; i++) begin
         ins_start[i] = '0;
         ins_len[i]   = '0;
      end
   endtask

   // advance the read scan by one operation; on the last one queue its fragments
   task automatic scan_cigar_op(input cigar_op_type op);
      logic [LEN_WIDTH:0] sum;
      len_type            trailing;
      logic               clip_cls;
      logic               ins_cls;
      frag_type           f;
      frag_type           emit [$];
      int                 pos;
      int                 k;
      if (op.code != CIGAR_H) begin
         if (!seen_body) begin
            seen_body = 1'b1;
            lead_clip = (op.code == CIGAR_S) ? op.len : '0;
         end
         tail_soft = (op.code == CIGAR_S);
         tail_len  = op.len;
      end
      if (op.code == CIGAR_I && op.len >= insert_thresh) begin
         pos = 0;
         while (pos < ins_cnt && ins_len[pos] >= op.len) pos++;
         if (pos < TOP_INSERTS) begin
            if (ins_cnt < TOP_INSERTS) ins_cnt++;
            for (k = ins_cnt - 1; k > pos; k--) begin
               ins_start[k] = ins_start[k-1];
               ins_len[k]   = ins_len[k-1];
            end
            ins_start[pos] = qpos;
            ins_len[pos]   = op.len;
         end
      end
      if (consumes_query(op.code)) begin
         sum  = {1'b0, qpos} + {1'b0, op.len};
         qpos = sum[LEN_WIDTH] ? LEN_MAX : sum[LEN_WIDTH-1:0];
      end
      if (!op.last) return;

      trailing = tail_soft ? tail_len : '0;
      clip_cls = (lead_clip >= clip_thresh) || (trailing >= clip_thresh);
      ins_cls  = (ins_cnt > 0);
      f = '0;
      f.split_cls = op.flags[0] | op.flags[1];
      f.clip_cls  = clip_cls;
      f.ins_cls   = ins_cls;
      f.reverse   = op.flags[2];
      if (lead_clip >= clip_thresh && lead_clip != '0) begin
         f.kind   = KIND_LEFT;
         f.start  = '0;
         f.length = lead_clip;
         emit.insert(emit.size(), f);
      end
      if (trailing >= clip_thresh && trailing != '0) begin
         f.kind   = KIND_RIGHT;
         f.start  = (op.rlen >= trailing) ? op.rlen - trailing : '0;
         f.length = trailing;
         emit.insert(emit.size(), f);
      end
      for (k = 0; k < ins_cnt; k++) begin
         if (ins_len[k] != '0) begin
            f.kind   = KIND_INSERT;
            f.start  = ins_start[k];
            f.length = ins_len[k];
            emit.insert(emit.size(), f);
         end
      end
      foreach (emit[j]) begin
         if (j < RESULT_CAP) begin
            f      = emit[j];
            f.last = (j == emit.size() - 1) || (j == RESULT_CAP - 1);
            frags_due.insert(frags_due.size(), f);
         end
      end
      clear_scan();
   endtask

   task automatic flag_error(input string msg);
      errors++;
      if (errors <= REPORT_MAX) $display("%s", msg);
   endtask

   // call at a clock edge; writes both thresholds back to back
   task automatic write_cfg(input len_type clip, input len_type ins);
      csr_valid <= 1'b1;
      csr_index <= CSR_MIN_CLIP;
      csr_data  <= clip;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      clip_thresh = clip;
      csr_index <= CSR_MIN_INSERT;
      csr_data  <= ins;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      insert_thresh = ins;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      while (ops_taken != ops_sent || frags_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic add_op(input logic [CODE_W-1:0] code, input len_type len, input logic last,
                         input len_type rlen, input logic [2:0] flags);
      cigar_op_type op;
      op.code  = code;
      op.len   = len;
      op.last  = last;
      op.rlen  = rlen;
      op.flags = flags;
      cigar_ops.insert(cigar_ops.size(), op);
      ops_sent++;
   endtask

   task automatic gen_read();
      cigar_op_type       ops [$];
      cigar_op_type       op;
      logic [2:0]         fl;
      logic [LEN_WIDTH:0] qsum;
      len_type            rlen;
      int                 n;
      int                 r;
      bit                 noisy;
      noisy   = ($urandom_range(0, 4) == 0);
      fl      = 3'($urandom_range(0, 7));
      qsum    = '0;
      op      = '0;
      op.flags = fl;
      if (noisy) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            op.code  = 4'($urandom_range(0, 15));
            op.len   = rand_len();
            op.flags = 3'($urandom_range(0, 7));
            ops.insert(ops.size(), op);
         end
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            op.code = CIGAR_H;
            op.len  = rand_len();
            ops.insert(ops.size(), op);
         end
         if ($urandom_range(0, 1) == 0) begin
            op.code = CIGAR_S;
            op.len  = rand_len();
            ops.insert(ops.size(), op);
         end
         n = $urandom_range(0, 5);
         repeat (n) begin
            op.code = pick_mid_code();
            op.len  = rand_len();
            ops.insert(ops.size(), op);
         end
         if ($urandom_range(0, 1) == 0) begin
            op.code = CIGAR_S;
            op.len  = rand_len();
            ops.insert(ops.size(), op);
         end
         if ($urandom_range(0, 3) == 0) begin
            op.code = CIGAR_H;
            op.len  = rand_len();
            ops.insert(ops.size(), op);
         end
         if (ops.size() == 0) begin
            op.code = CIGAR_M;
            op.len  = rand_len();
            ops.insert(ops.size(), op);
         end
      end
      foreach (ops[j]) begin
         if (consumes_query(ops[j].code)) begin
            qsum = qsum + {1'b0, ops[j].len};
            if (qsum[LEN_WIDTH]) qsum = {1'b0, LEN_MAX};
         end
      end
      r = $urandom_range(0, 9);
      if (r < 5) rlen = qsum[LEN_WIDTH-1:0];
      else if (r < 8) rlen = len_type'($urandom_range(0, 100));
      else rlen = len_type'($urandom);
      foreach (ops[j]) begin
         if (j == ops.size() - 1) begin
            add_op(ops[j].code, ops[j].len, 1'b1, rlen, fl);
         end else begin
            add_op(ops[j].code, ops[j].len, 1'b0, rlen, ops[j].flags);
         end
      end
   endtask

   task automatic push_random(input int n_items);
      int first;
      first = ops_sent;
      while (ops_sent - first < n_items) gen_read();
   endtask

   // sender: one transfer per handshake, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_cigar_op(cur_op);
            ops_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (cigar_ops.size() != 0) begin
               cur_op = cigar_ops.pop_front();
               req_tdata  <= {4'b0, cur_op.rlen, cur_op.len, cur_op.code};
               req_tuser  <= cur_op.flags;
               req_tlast  <= cur_op.last;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
               req_gap = req_steady ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each fragment transfer, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind      = rsp_tuser[1:0];
            got.start     = rsp_tdata[LEN_WIDTH-1:0];
            got.length    = rsp_tdata[2*LEN_WIDTH-1:LEN_WIDTH];
            got.split_cls = rsp_tuser[2];
            got.clip_cls  = rsp_tuser[3];
            got.ins_cls   = rsp_tuser[4];
            got.reverse   = rsp_tuser[5];
            got.last      = rsp_tlast;
            if (frags_due.size() == 0) begin
               flag_error($sformatf("unexpected fragment: kind %0d start %0d len %0d",
                                    got.kind, got.start, got.length));
            end else begin
               want = frags_due.pop_front();
               if (got.kind !== want.kind || got.start !== want.start ||
                   got.length !== want.length || got.split_cls !== want.split_cls ||
                   got.clip_cls !== want.clip_cls || got.ins_cls !== want.ins_cls ||
                   got.reverse !== want.reverse || got.last !== want.last) begin
                  flag_error($sformatf({"fragment mismatch: expected kind %0d start %0d ",
                     "len %0d split/clip/ins %b%b%b rev %b last %b, got kind %0d ",
                     "start %0d len %0d split/clip/ins %b%b%b rev %b last %b"},
                     want.kind, want.start, want.length, want.split_cls, want.clip_cls,
                     want.ins_cls, want.reverse, want.last, got.kind, got.start,
                     got.length, got.split_cls, got.clip_cls, got.ins_cls, got.reverse,
                     got.last));
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
            rsp_stall = rsp_steady ? 0 : pick_gap();
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      clear_scan();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_cfg('0, '0);
      // hard clips around soft clips, zero-length insertion ranked but dropped
      add_op(CIGAR_H, 28'd2, 1'b0, 28'd31, 3'b001);
      add_op(CIGAR_S, 28'd5, 1'b0, 28'd31, 3'b001);
      add_op(CIGAR_M, 28'd10, 1'b0, 28'd31, 3'b001);
      add_op(CIGAR_I, 28'd3, 1'b0, 28'd31, 3'b001);
      add_op(OP_D, 28'd4, 1'b0, 28'd31, 3'b001);
      add_op(CIGAR_I, 28'd0, 1'b0, 28'd31, 3'b001);
      add_op(CIGAR_M, 28'd6, 1'b0, 28'd31, 3'b001);
      add_op(CIGAR_S, 28'd7, 1'b0, 28'd31, 3'b001);
      add_op(CIGAR_H, 28'd1, 1'b1, 28'd31, 3'b001);
      // lone soft clip is both clips; right start clamps to zero
      add_op(CIGAR_S, 28'd9, 1'b1, 28'd4, 3'b110);
      // only zero-length insertions: no fragment at all
      add_op(CIGAR_I, 28'd0, 1'b0, 28'd5, 3'b000);
      add_op(CIGAR_M, 28'd5, 1'b0, 28'd5, 3'b000);
      add_op(CIGAR_I, 28'd0, 1'b1, 28'd5, 3'b000);
      // saturating position, reserved codes, ranking ties
      add_op(CIGAR_M, LEN_MAX, 1'b0, LEN_MAX, 3'b101);
      add_op(CIGAR_X, LEN_MAX, 1'b0, LEN_MAX, 3'b010);
      add_op(OP_RSVD_LO, 28'd5, 1'b0, LEN_MAX, 3'b101);
      add_op(CIGAR_I, 28'd4, 1'b0, LEN_MAX, 3'b101);
      add_op(CIGAR_I, 28'd6, 1'b0, LEN_MAX, 3'b101);
      add_op(CIGAR_I, 28'd6, 1'b0, LEN_MAX, 3'b101);
      add_op(CIGAR_I, 28'd2, 1'b0, LEN_MAX, 3'b101);
      add_op(CIGAR_EQ, 28'd3, 1'b0, LEN_MAX, 3'b101);
      add_op(OP_N, 28'd2, 1'b0, LEN_MAX, 3'b101);
      add_op(OP_P, 28'd1, 1'b0, LEN_MAX, 3'b101);
      add_op(OP_RSVD_HI, LEN_MAX, 1'b1, LEN_MAX, 3'b101);
      // hard clip only
      add_op(CIGAR_H, 28'd3, 1'b1, 28'd0, 3'b111);
      wait_drain();

      write_cfg(LEN_MAX, LEN_MAX);
      add_op(CIGAR_S, LEN_MAX, 1'b0, LEN_MAX, 3'b100);
      add_op(CIGAR_I, LEN_MAX - 28'd1, 1'b0, LEN_MAX, 3'b100);
      add_op(CIGAR_I, LEN_MAX, 1'b0, LEN_MAX, 3'b100);
      add_op(CIGAR_S, LEN_MAX, 1'b1, LEN_MAX, 3'b100);
      push_random(12);
      wait_drain();
      push_random(12);
      wait_drain();

      write_cfg(len_type'($urandom_range(0, 24)), len_type'($urandom_range(0, 24)));
      push_random(12);
      wait_drain();
      push_random(12);
      wait_drain();

      write_cfg(len_type'($urandom), len_type'($urandom_range(1, 6)));
      push_random(12);
      wait_drain();
      push_random(12);
      wait_drain();

      if (frags_due.size() != 0) flag_error("fragments still outstanding at end of run");
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
